// ----- design/tepf_pkg.sv -----
// Package for the timed entry pool: pool geometry, command and result codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tepf_pkg;
  localparam int POOL_DEPTH = 64;
  localparam int IDX_W = 6;
  localparam int PTR_W = 7;
  localparam logic [PTR_W-1:0] NIL = 7'd127;
  localparam logic [15:0] DEFAULT_LIFE_RESET = 16'd100;

  localparam logic [1:0] CMD_SPAWN = 2'd0;
  localparam logic [1:0] CMD_KILL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_KILL = 2'd1;
  localparam logic [1:0] KIND_LIVE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_WALK,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_EMIT,
    ST_UNLINK_O,
    ST_UNLINK_N,
    ST_DONE,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- design/tepf_div.sv -----
// Restoring divider, one quotient bit per cycle, for the fade scaling.
// Depends on tepf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tepf_div
  import tepf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] numer,
  input  wire logic [15:0] denom,
  output logic             busy,
  output logic [23:0]      quot
);
  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [16:0] trial;
  logic [23:0] num;
  logic [15:0] den;

  assign trial = {rem[15:0], num[23]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd24;
      rem  <= '0;
      num  <= numer;
      den  <= denom;
    end else if (busy) begin
      num <= {num[22:0], ~trial[16]};
      rem <= trial[16] ? {rem[15:0], num[23]} : trial;
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
  assign quot = num;
endmodule
`default_nettype wire

// ----- design/timed_entry_pool_with_fade_top.sv -----
// Top level of the timed entry pool with fade-out: sequencer, entry stores,
// link lists and result register. Depends on tepf_pkg and tepf_div.
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Dir | Payload
// s_axis    | in  | tdata: cmd, now_ms, tag, life_ms, fade_ms, r, g, b, a
// m_axis    | out | tdata: slot, evicted, freed_count, r, g, b, a; tuser kind
// cfg       | in  | default_life_ms write
//
// A spawn passes through the spawn and output states after its accept before
// its beat is valid. Kill and tick walk the live list oldest first: each
// entry is fetched, read and evaluated, an entry that is freed then goes
// through the two unlink states, and a tick sends a kept entry through the
// divide and emit states. Each fading channel is one pass through the shared
// divider (start, a 24-bit quotient, write back). Ending a walk passes through
// the done and output states. Each live report waits in a holding register
// until the next one shows it is not the last; the walk stalls while the
// output register is still full. Reset is synchronous; the free list is
// rebuilt by a sweep over all 64 entries after reset, when no beat is accepted.
module timed_entry_pool_with_fade_top
  import tepf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[1:0], now_ms[33:2], tag[41:34], life_ms[57:42], fade_ms[73:58],
  // red[81:74], green[89:82], blue[97:90], alpha[105:98], zero fill
  input  wire logic [111:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot[5:0], evicted[6], freed_count[13:7], red[21:14], green[29:22],
  // blue[37:30], alpha[45:38], zero fill
  output logic [47:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  // Entry stores, read and written in clocked blocks.
  logic [7:0]       mem_tag [POOL_DEPTH];
  logic [31:0]      mem_exp [POOL_DEPTH];
  logic [31:0]      mem_fst [POOL_DEPTH];
  logic [15:0]      mem_flen [POOL_DEPTH];
  logic [31:0]      mem_col [POOL_DEPTH];
  logic [PTR_W-1:0] mem_old [POOL_DEPTH];
  logic [PTR_W-1:0] mem_new [POOL_DEPTH];

  logic [15:0]      default_life;
  logic [PTR_W-1:0] free_head, newest, oldest;
  logic [IDX_W:0]   init_cnt;
  logic             init_busy;
  state_t           state, state_next;

  logic [1:0]       cmd;
  logic [31:0]      now;
  logic [7:0]       tag;
  logic [15:0]      life, fade;
  logic [31:0]      color_in;
  logic [PTR_W-1:0] cur, nx, od;
  logic [7:0]       r_tag;
  logic [31:0]      r_exp, r_fst, r_col;
  logic [15:0]      r_flen;
  logic [6:0]       cnt;
  logic [31:0]      rem;
  logic [15:0]      rem_c;
  logic [1:0]       ch;
  logic [31:0]      col_out;
  logic             pend_valid;
  logic [5:0]       pend_slot;
  logic [31:0]      pend_col;

  logic             div_start, div_busy;
  logic [23:0]      div_q;
  logic [23:0]      div_n;

  assign div_n = {8'd0, rem_c} * {16'd0, col_out[8*ch +: 8]};

  tepf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_n),
    .denom(r_flen), .busy(div_busy), .quot(div_q)
  );

  function automatic logic vld(input logic [PTR_W-1:0] p);
    return p < PTR_W'(POOL_DEPTH);
  endfunction

  // An entry fades once the time since its fade start is nonzero and not negative.
  logic [31:0] since;
  logic        fading;
  assign since = now - r_fst;
  assign fading = since != 32'd0 && !since[31];

  always_ff @(posedge clk) begin
    if (rst) default_life <= DEFAULT_LIFE_RESET;
    else if (cfg_we) default_life <= cfg_wdata;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tdata[1:0])
          CMD_SPAWN: state_next = ST_SPAWN;
          CMD_KILL, CMD_TICK: state_next = ST_WALK;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SPAWN: state_next = ST_OUT;
      ST_WALK: state_next = vld(cur) ? ST_READ : ST_DONE;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (cmd == CMD_KILL) state_next = (r_tag == tag) ? ST_UNLINK_O : ST_WALK;
        else if (rem == 32'd0 || rem[31]) state_next = ST_UNLINK_O;
        else state_next = ST_DIV;
      end
      // The last channel is written back as the sequencer leaves.
      ST_DIV: if (!div_busy && !div_start && ch == 2'd3) state_next = ST_EMIT;
      ST_EMIT: if (!pend_valid || !m_axis_tvalid || m_axis_tready)
        state_next = ST_WALK;
      ST_UNLINK_O: state_next = ST_UNLINK_N;
      ST_UNLINK_N: state_next = ST_WALK;
      ST_DONE: state_next = ST_OUT;
      ST_OUT: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !init_busy && !m_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      free_head <= '0;
      newest <= NIL;
      oldest <= NIL;
      init_busy <= 1'b1;
      init_cnt <= '0;
      m_axis_tvalid <= 1'b0;
      pend_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      div_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (init_busy) begin
        mem_new[init_cnt[IDX_W-1:0]] <= (init_cnt == 7'(POOL_DEPTH - 1)) ? NIL
                                        : PTR_W'(init_cnt + 7'd1);
        init_cnt <= init_cnt + 7'd1;
        if (init_cnt == 7'(POOL_DEPTH - 1)) init_busy <= 1'b0;
      end
      case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd <= s_axis_tdata[1:0];
          now <= s_axis_tdata[33:2];
          tag <= s_axis_tdata[41:34];
          life <= (s_axis_tdata[57:42] == 16'd0) ? default_life : s_axis_tdata[57:42];
          fade <= s_axis_tdata[73:58];
          color_in <= s_axis_tdata[105:74];
          cur <= oldest;
          // Successor of the oldest entry, needed if a spawn has to evict it.
          nx <= mem_new[oldest[IDX_W-1:0]];
          cnt <= '0;
        end
        ST_SPAWN: begin : spawn
          logic [PTR_W-1:0] x;
          logic [15:0] f;
          f = (fade > life) ? life : fade;
          if (vld(free_head)) begin
            x = free_head;
            free_head <= mem_new[free_head[IDX_W-1:0]];
            pend_col[6] <= 1'b0;
          end else begin
            // Evict the oldest: it is the list head, so only its successor moves.
            x = oldest;
            pend_col[6] <= 1'b1;
          end
          mem_new[x[IDX_W-1:0]] <= NIL;
          if (!vld(free_head) && newest == oldest) begin
            mem_old[x[IDX_W-1:0]] <= NIL;
            oldest <= x;
          end else if (!vld(free_head)) begin
            mem_old[nx[IDX_W-1:0]] <= NIL;
            oldest <= nx;
            mem_old[x[IDX_W-1:0]] <= newest;
            mem_new[newest[IDX_W-1:0]] <= x;
          end else begin
            mem_old[x[IDX_W-1:0]] <= newest;
            if (vld(newest)) mem_new[newest[IDX_W-1:0]] <= x;
            else oldest <= x;
          end
          newest <= x;
          mem_tag[x[IDX_W-1:0]] <= tag;
          mem_exp[x[IDX_W-1:0]] <= now + {16'd0, life};
          mem_fst[x[IDX_W-1:0]] <= now + {16'd0, life - f};
          mem_flen[x[IDX_W-1:0]] <= f;
          mem_col[x[IDX_W-1:0]] <= color_in;
          pend_slot <= x[IDX_W-1:0];
        end
        ST_WALK: if (vld(cur)) begin
          nx <= mem_new[cur[IDX_W-1:0]];
          od <= mem_old[cur[IDX_W-1:0]];
          r_tag <= mem_tag[cur[IDX_W-1:0]];
          r_exp <= mem_exp[cur[IDX_W-1:0]];
          r_fst <= mem_fst[cur[IDX_W-1:0]];
          r_flen <= mem_flen[cur[IDX_W-1:0]];
          r_col <= mem_col[cur[IDX_W-1:0]];
        end
        ST_READ: begin
          rem <= r_exp - now;
        end
        ST_EVAL: begin
          rem_c <= (rem > {16'd0, r_flen}) ? r_flen : rem[15:0];
          col_out <= r_col;
          ch <= 2'd0;
          if (cmd == CMD_TICK && !(rem == 32'd0 || rem[31])) begin
            if (fading && r_flen != 16'd0) div_start <= 1'b1;
            else begin
              if (fading) col_out <= '0;
              ch <= 2'd3;
            end
          end
          if (cmd == CMD_KILL && r_tag != tag) cur <= nx;
        end
        ST_DIV: if (!div_busy && !div_start) begin
          if (fading && r_flen != 16'd0) col_out[8*ch +: 8] <= div_q[7:0];
          if (ch != 2'd3 && fading && r_flen != 16'd0) begin
            ch <= ch + 2'd1;
            div_start <= 1'b1;
          end
        end
        ST_EMIT: if (!pend_valid || !m_axis_tvalid || m_axis_tready) begin
          // A held report goes out once a later one proves it is not last.
          if (pend_valid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KIND_LIVE;
            m_axis_tlast <= 1'b0;
            m_axis_tdata <= {2'b0, pend_col, 7'd0, 1'b0, pend_slot};
          end
          pend_valid <= 1'b1;
          pend_slot <= cur[IDX_W-1:0];
          pend_col <= col_out;
          cur <= nx;
        end
        ST_UNLINK_O: begin
          if (vld(od)) mem_new[od[IDX_W-1:0]] <= nx; else oldest <= nx;
          if (vld(nx)) mem_old[nx[IDX_W-1:0]] <= od; else newest <= od;
        end
        ST_UNLINK_N: begin
          mem_new[cur[IDX_W-1:0]] <= free_head;
          free_head <= cur;
          cnt <= cnt + 7'd1;
          cur <= nx;
        end
        ST_DONE: ;
        ST_OUT: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tlast <= 1'b1;
          if (cmd == CMD_SPAWN) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KIND_SPAWN;
            m_axis_tdata <= {41'd0, pend_col[6], pend_slot};
          end else if (cmd == CMD_KILL) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KIND_KILL;
            m_axis_tdata <= {34'd0, cnt, 7'd0};
          end else if (pend_valid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= KIND_LIVE;
            m_axis_tdata <= {2'b0, pend_col, 7'd0, 1'b0, pend_slot};
          end
          pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) s_axis_tready |-> state == ST_IDLE;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !s_axis_tready) else $error("accept during init sweep");

  a_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == ST_EVAL || state == ST_DIV) else $error("stray divide");
endmodule
`default_nettype wire

// ----- tb/sv/timed_entry_pool_with_fade_top_tb.sv -----
// Testbench for the timed entry pool with fade-out: spawns, kills by tag and
// ticks checked against an in-bench pool predictor. Depends on tepf_pkg and the RTL.
`timescale 1ns / 1ps
module timed_entry_pool_with_fade_top_tb
  import tepf_pkg::*;
();

  localparam int NONE = 127;
  localparam int QUIET_LIMIT = 200000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // One beat on the output side, as the predictor builds it.
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot;
    logic       evicted;
    logic [6:0] freed;
    logic [31:0] color;
    logic       last;
  } pool_beat_t;

  // Pool mirror: age-ordered live list plus free list.
  logic [7:0]  p_tag [64];
  logic [31:0] p_expiry [64];
  logic [31:0] p_fade_start [64];
  logic [15:0] p_fade_len [64];
  logic [31:0] p_color [64];
  int p_older [64];
  int p_newer [64];
  int free_top, newest, oldest;
  logic [15:0] life_default;

  logic [111:0] cmd_queue[$];
  pool_beat_t   awaited_beats[$];
  bit           hold_sender;
  int  mismatches, quiet_cycles, send_gap, take_gap;

  timed_entry_pool_with_fade_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void pool_clear();
    for (int i = 0; i < 64; i++) begin
      p_newer[i] = (i < 63) ? i + 1 : NONE;
      p_older[i] = 0;
    end
    free_top = 0;
    newest = NONE;
    oldest = NONE;
    life_default = DEFAULT_LIFE_RESET;
  endfunction

  function automatic void pool_unlink(int x);
    int o, n;
    o = p_older[x];
    n = p_newer[x];
    if (o != NONE) p_newer[o] = n; else oldest = n;
    if (n != NONE) p_older[n] = o; else newest = o;
  endfunction

  function automatic void pool_free(int x);
    pool_unlink(x);
    p_newer[x] = free_top;
    free_top = x;
  endfunction

  function automatic logic [31:0] fade_color(logic [31:0] c, logic [31:0] rem,
                                             logic [15:0] len);
    logic [31:0] r;
    logic [31:0] ch;
    r = '0;
    if (len == 0) return '0;
    if (rem > len) rem = len;
    for (int k = 0; k < 4; k++) begin
      ch = ((c >> (8 * k)) & 32'hFF) * rem / len;
      r[8*k +: 8] = ch[7:0];
    end
    return r;
  endfunction

  // Applies one accepted command to the mirror and queues its result beats.
  function automatic void pool_apply(logic [111:0] d);
    logic [1:0] cmd;
    logic [31:0] now, life, fade, rem, since, col;
    logic [7:0] tg;
    int x, nx, cnt, first;
    bit ev;
    pool_beat_t b;
    cmd = d[1:0];
    now = d[33:2];
    tg = d[41:34];
    life = {16'd0, d[57:42]};
    fade = {16'd0, d[73:58]};
    b = '0;
    case (cmd)
      CMD_SPAWN: begin
        if (life == 0) life = {16'd0, life_default};
        if (fade > life) fade = life;
        ev = 1'b0;
        if (free_top != NONE) begin
          x = free_top;
          free_top = p_newer[x];
        end else begin
          x = oldest;
          pool_unlink(x);
          ev = 1'b1;
        end
        p_newer[x] = NONE;
        p_older[x] = newest;
        if (newest != NONE) p_newer[newest] = x; else oldest = x;
        newest = x;
        p_tag[x] = tg;
        p_expiry[x] = now + life;
        p_fade_start[x] = now + (life - fade);
        p_fade_len[x] = fade[15:0];
        p_color[x] = d[105:74];
        b.kind = KIND_SPAWN;
        b.slot = x[5:0];
        b.evicted = ev;
        b.last = 1'b1;
        awaited_beats.push_back(b);
      end
      CMD_KILL: begin
        cnt = 0;
        x = oldest;
        while (x != NONE) begin
          nx = p_newer[x];
          if (p_tag[x] == tg) begin
            pool_free(x);
            cnt++;
          end
          x = nx;
        end
        b.kind = KIND_KILL;
        b.freed = cnt[6:0];
        b.last = 1'b1;
        awaited_beats.push_back(b);
      end
      CMD_TICK: begin
        first = awaited_beats.size();
        x = oldest;
        while (x != NONE) begin
          nx = p_newer[x];
          rem = p_expiry[x] - now;
          since = now - p_fade_start[x];
          if (rem == 0 || rem[31]) begin
            pool_free(x);
          end else begin
            col = p_color[x];
            if (since != 0 && !since[31]) col = fade_color(col, rem, p_fade_len[x]);
            b = '0;
            b.kind = KIND_LIVE;
            b.slot = x[5:0];
            b.color = col;
            awaited_beats.push_back(b);
          end
          x = nx;
        end
        if (awaited_beats.size() > first) awaited_beats[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [111:0] pack_cmd(logic [1:0] cmd, logic [31:0] now,
      logic [7:0] tg, logic [15:0] life, logic [15:0] fade, logic [31:0] rgba);
    return {6'd0, rgba, fade, life, tg, now, cmd};
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  // Driver: the valid stays high across back-to-back beats; one NBA per step.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the beat
    end else begin
      if (s_axis_tvalid) pool_apply(s_axis_tdata);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0 && !hold_sender) begin
        s_axis_tdata <= cmd_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, field-by-field compare with the oldest beat.
  always @(posedge clk) begin
    pool_beat_t want;
    pool_beat_t seen;
    if (rst) begin
      m_axis_tready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind = m_axis_tuser;
        seen.slot = m_axis_tdata[5:0];
        seen.evicted = m_axis_tdata[6];
        seen.freed = m_axis_tdata[13:7];
        seen.color = m_axis_tdata[45:14];
        seen.last = m_axis_tlast;
        if (awaited_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %h", seen);
        end else begin
          want = awaited_beats.pop_front();
          if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch kd %0d/%0d sl %0d/%0d ev %0d/%0d fc %0d/%0d c %h/%h lt %0d/%0d",
                       want.kind, seen.kind, want.slot, seen.slot, want.evicted,
                       seen.evicted, want.freed, seen.freed, want.color, seen.color,
                       want.last, seen.last);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) take_gap <= pick_gap();
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Waits until every beat is back and the block is idle again; a tick that
  // reports nothing may still be freeing entries after the last beat.
  task automatic drain();
    while (cmd_queue.size() > 0 || s_axis_tvalid || awaited_beats.size() > 0 ||
           !s_axis_tready)
      @(posedge clk);
  endtask

  task automatic set_life_default(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    life_default = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase: mostly a small time window so entries live, fade and expire.
  task automatic random_phase(int n, ref logic [31:0] clock_ms);
    logic [1:0] cmd;
    logic [15:0] life, fade;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_SPAWN;
        4: cmd = CMD_KILL;
        9: cmd = ($urandom_range(0, 5) == 0) ? CMD_UNUSED : CMD_TICK;
        default: cmd = CMD_TICK;
      endcase
      clock_ms += $urandom_range(0, 40);
      life = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
      fade = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
      cmd_queue.push_back(pack_cmd(cmd, clock_ms, 8'($urandom_range(0, 3)) |
          (($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0), life, fade, $urandom));
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    pool_clear();
    hold_sender = 1'b0;
    mismatches = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each command, the ignored code, empty tick, wrap.
    clock_ms = 32'hFFFF_FFF0;
    cmd_queue.push_back(pack_cmd(CMD_TICK, clock_ms, 8'd0, 16'd0, 16'd0, 32'd0));
    cmd_queue.push_back(pack_cmd(CMD_SPAWN, clock_ms, 8'hFF, 16'hFFFF, 16'hFFFF,
                                 32'hFFFF_FFFF));
    cmd_queue.push_back(pack_cmd(CMD_SPAWN, clock_ms, 8'h00, 16'd0, 16'd50, 32'h8040_2010));
    cmd_queue.push_back(pack_cmd(CMD_SPAWN, clock_ms, 8'h01, 16'd40, 16'd0, 32'h1234_5678));
    cmd_queue.push_back(pack_cmd(CMD_UNUSED, clock_ms, 8'h01, 16'hFFFF, 16'hFFFF,
                                 32'hFFFF_FFFF));
    cmd_queue.push_back(pack_cmd(CMD_TICK, clock_ms + 32'd30, 8'd0, 16'd0, 16'd0, 32'd0));
    cmd_queue.push_back(pack_cmd(CMD_TICK, clock_ms + 32'd90, 8'd0, 16'd0, 16'd0, 32'd0));
    cmd_queue.push_back(pack_cmd(CMD_KILL, clock_ms, 8'h77, 16'd0, 16'd0, 32'd0));
    cmd_queue.push_back(pack_cmd(CMD_KILL, clock_ms, 8'hFF, 16'd0, 16'd0, 32'd0));
    cmd_queue.push_back(pack_cmd(CMD_TICK, 32'h7FFF_FFFF, 8'd0, 16'd0, 16'd0, 32'd0));
    // Overfill the pool so spawns start evicting the oldest entry.
    for (int i = 0; i < 70; i++)
      cmd_queue.push_back(pack_cmd(CMD_SPAWN, 32'd1000, 8'(i % 4), 16'd5000, 16'd4000,
                                   $urandom));
    drain();

    // Hold the sender until every result is back, then burst a full-pool tick.
    hold_sender = 1'b1;
    cmd_queue.push_back(pack_cmd(CMD_TICK, 32'd3000, 8'd0, 16'd0, 16'd0, 32'd0));
    while (awaited_beats.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    clock_ms = 32'd10000;
    set_life_default(16'hFFFF);
    random_phase(60, clock_ms);
    drain();
    set_life_default(16'd0);
    random_phase(40, clock_ms);
    drain();
    set_life_default(16'd1);
    random_phase(40, clock_ms);
    drain();
    set_life_default(16'd120);
    clock_ms = 32'hFFFF_FF00;
    random_phase(60, clock_ms);
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
